// ===== hdl/sfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder package
// Shared types, byte codes and CRC-16 helpers for the stuffed frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] ESC_BYTE   = 8'h10;
    localparam logic [7:0] END_BYTE   = 8'h04;

    localparam int unsigned QueueDepthDefault = 4;

    // Output byte positions of one input transaction, in line order.
    typedef enum logic [2:0] {
        SLOT_START,
        SLOT_ESC_DATA,
        SLOT_DATA,
        SLOT_ESC_LO,
        SLOT_CRC_LO,
        SLOT_ESC_HI,
        SLOT_CRC_HI,
        SLOT_END
    } t_sfe_slot;

    localparam int unsigned NumSlots = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_sfe_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } t_sfe_out;

    // One classified input byte waiting for the back end.
    typedef struct packed {
        logic [7:0]          data_byte;
        logic [15:0]         crc;
        logic [NumSlots-1:0] slot_mask;
    } t_sfe_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_sfe_qstat;

    function automatic logic [15:0] crc_nib_lut(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'h0: val = 16'h0000;
            4'h1: val = 16'h1021;
            4'h2: val = 16'h2042;
            4'h3: val = 16'h3063;
            4'h4: val = 16'h4084;
            4'h5: val = 16'h50A5;
            4'h6: val = 16'h60C6;
            4'h7: val = 16'h70E7;
            4'h8: val = 16'h8108;
            4'h9: val = 16'h9129;
            4'hA: val = 16'hA14A;
            4'hB: val = 16'hB16B;
            4'hC: val = 16'hC18C;
            4'hD: val = 16'hD1AD;
            4'hE: val = 16'hE1CE;
            4'hF: val = 16'hF1EF;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
        return crc_nib_lut(crc[15:12] ^ nib) ^ {crc[11:0], 4'h0};
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        return crc_nibble(crc_nibble(crc, b[7:4]), b[3:0]);
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == START_BYTE) || (b == ESC_BYTE) || (b == END_BYTE);
    endfunction

endpackage

// ===== hdl/stuffed_frame_encoder_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder with CRC-16
// Frames command and payload bytes with start, escape, CRC and end bytes.
// ----------------------------------------------------------------------------
// Each input transaction is one command or payload byte; it is accepted
// whenever the entry queue (QUEUE_DEPTH entries) has room, and the running
// CRC-16 (0x1021, initial 0) is updated as it enters. The back end sends one
// line byte per cycle while the output is not stalled, so an input byte yields
// between 1 and 8 line bytes: 1 for a plain payload byte, 2 when it is escaped,
// plus the start byte on the first byte of a frame and up to 5 more (escaped
// CRC bytes and the end byte) on the final one. Sustained throughput is
// therefore set by the output port at one byte per cycle when not stalled;
// plain payload flows at one byte per cycle, and the first line byte of a
// transaction passes the entry queue, then the registered output stage.
module stuffed_frame_encoder_crc16 #(
    parameter int unsigned QUEUE_DEPTH = sfe_pkg::QueueDepthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  sfe_pkg::t_sfe_in i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output sfe_pkg::t_sfe_out o_data
);
    import sfe_pkg::*;

    t_sfe_qstat qstat;
    t_sfe_entry push_entry;
    t_sfe_entry head_entry;
    logic       push;
    logic       pop;

    sfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (push_entry)
    );

    sfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_qstat (qstat)
    );

    sfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== hdl/sfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder front end
// Accepts input bytes, keeps the running CRC and frame state, and classifies
// each byte into the set of line bytes it will produce.
// ----------------------------------------------------------------------------
module sfe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sfe_pkg::t_sfe_in   i_data,
    input  sfe_pkg::t_sfe_qstat i_qstat,
    output logic               o_push,
    output sfe_pkg::t_sfe_entry o_entry
);
    import sfe_pkg::*;

    logic        r_inside;
    logic        n_inside;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_upd;
    logic        fin;

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;
    assign fin     = i_data.final_byte;

    // A new frame starts from a cleared CRC.
    assign crc_upd = crc_byte(r_inside ? r_crc : 16'h0000, i_data.data_byte);

    always_comb begin
        o_entry           = '0;
        o_entry.data_byte = i_data.data_byte;
        o_entry.crc       = crc_upd;
        o_entry.slot_mask[SLOT_START]    = !r_inside;
        o_entry.slot_mask[SLOT_ESC_DATA] = needs_escape(i_data.data_byte);
        o_entry.slot_mask[SLOT_DATA]     = 1'b1;
        o_entry.slot_mask[SLOT_ESC_LO]   = fin && needs_escape(crc_upd[7:0]);
        o_entry.slot_mask[SLOT_CRC_LO]   = fin;
        o_entry.slot_mask[SLOT_ESC_HI]   = fin && needs_escape(crc_upd[15:8]);
        o_entry.slot_mask[SLOT_CRC_HI]   = fin;
        o_entry.slot_mask[SLOT_END]      = fin;
    end

    always_comb begin
        n_inside = r_inside;
        n_crc    = r_crc;
        if (o_push) begin
            n_inside = !fin;
            n_crc    = fin ? 16'h0000 : crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_crc    <= 16'h0000;
        end else begin
            r_inside <= n_inside;
            r_crc    <= n_crc;
        end
    end

`ifndef SYNTHESIS
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && fin) |=> (!r_inside && r_crc == 16'h0000))
        else $error("frame state not cleared after final byte");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_inside == !$past(fin))
        else $error("frame state out of step with final flag");
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> ($stable(r_crc) && $stable(r_inside)))
        else $error("front state changed without a transaction");
`endif

endmodule

// ===== hdl/sfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder queue
// Short FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module sfe_queue #(
    parameter int unsigned DEPTH = sfe_pkg::QueueDepthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfe_pkg::t_sfe_entry i_entry,
    input  logic                i_pop,
    output sfe_pkg::t_sfe_entry o_head,
    output sfe_pkg::t_sfe_qstat o_qstat
);
    import sfe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_sfe_entry      r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");
    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/sfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder back end
// Walks the slots of the head entry one line byte per cycle, while the output
// is not stalled, into a registered output stage, and releases the entry with its last byte.
// ----------------------------------------------------------------------------
module sfe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfe_pkg::t_sfe_entry i_head,
    input  sfe_pkg::t_sfe_qstat i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output sfe_pkg::t_sfe_out   o_data
);
    import sfe_pkg::*;

    logic [NumSlots-1:0] r_done;
    logic [NumSlots-1:0] n_done;
    logic                r_o_valid;
    logic                n_o_valid;
    t_sfe_out            r_o_data;
    t_sfe_out            n_o_data;
    logic [NumSlots-1:0] cur;
    logic [NumSlots-1:0] low;
    logic [NumSlots-1:0] rest;
    t_sfe_slot           slot;
    logic                advance;
    logic [7:0]          slot_byte;

    assign cur     = i_head.slot_mask & ~r_done;
    assign advance = !i_qstat.empty && (!r_o_valid || !i_stall);

    // Lowest pending slot goes out next.
    always_comb begin
        slot = SLOT_END;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            if (cur[i]) begin
                slot = t_sfe_slot'(3'(i));
            end
        end
    end

    assign low  = NumSlots'(1) << slot;
    assign rest = cur & ~low;

    always_comb begin
        case (slot)
            SLOT_START:    slot_byte = START_BYTE;
            SLOT_ESC_DATA: slot_byte = ESC_BYTE;
            SLOT_DATA:     slot_byte = i_head.data_byte;
            SLOT_ESC_LO:   slot_byte = ESC_BYTE;
            SLOT_CRC_LO:   slot_byte = i_head.crc[7:0];
            SLOT_ESC_HI:   slot_byte = ESC_BYTE;
            SLOT_CRC_HI:   slot_byte = i_head.crc[15:8];
            SLOT_END:      slot_byte = END_BYTE;
            default:       slot_byte = END_BYTE;
        endcase
    end

    assign o_pop = advance && (rest == '0);

    always_comb begin
        n_done    = r_done;
        n_o_valid = r_o_valid && i_stall;
        n_o_data  = r_o_data;
        if (advance) begin
            n_o_valid           = 1'b1;
            n_o_data.out_byte   = slot_byte;
            n_o_data.run_last   = (rest == '0);
            n_o_data.frame_last = (slot == SLOT_END);
            n_done              = (rest == '0) ? '0 : (r_done | low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_done    <= n_done;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data <= n_o_data;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.frame_last) |->
            (r_o_data.run_last && r_o_data.out_byte == END_BYTE))
        else $error("closing byte not marked as last of its transaction");
    a_head_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> cur != '0)
        else $error("head entry has no pending slot");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> ($stable(r_done) && r_o_valid))
        else $error("back end moved while output stalled");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qstat.empty |-> r_done == '0)
        else $error("slot progress left over with empty queue");
`endif

endmodule

// ===== tb/sv/stuffed_frame_encoder_crc16_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder checker
// Watches both channels of the encoder, predicts the stuffed line bytes of
// every accepted input transaction and compares each output transaction,
// field by field, with the oldest predicted line byte.
// ----------------------------------------------------------------------------
module stuffed_frame_encoder_crc16_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  sfe_pkg::t_sfe_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  sfe_pkg::t_sfe_out i_out_data,
    output int                o_mismatches,
    output int                o_outstanding
);
    import sfe_pkg::*;

    t_sfe_out    line_bytes_q[$];
    logic [15:0] frame_crc;
    logic        in_frame;
    int          mismatches = 0;

    // Bit-serial CRC-16, polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ 16'h1021;
            end
        end
        return c;
    endfunction

    task automatic predict_line_bytes(input t_sfe_in item);
        logic [7:0] raw[3];
        logic [7:0] line[8];
        int         n_raw;
        int         n;
        n     = 0;
        n_raw = 1;
        if (!in_frame) begin
            line[n]   = START_BYTE;
            n++;
            frame_crc = '0;
            in_frame  = 1'b1;
        end
        raw[0]    = item.data_byte;
        frame_crc = crc16_update(frame_crc, item.data_byte);
        if (item.final_byte) begin
            raw[1] = frame_crc[7:0];
            raw[2] = frame_crc[15:8];
            n_raw  = 3;
        end
        for (int k = 0; k < n_raw; k++) begin
            if (raw[k] inside {START_BYTE, ESC_BYTE, END_BYTE}) begin
                line[n] = ESC_BYTE;
                n++;
            end
            line[n] = raw[k];
            n++;
        end
        if (item.final_byte) begin
            line[n]   = END_BYTE;
            n++;
            frame_crc = '0;
            in_frame  = 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            line_bytes_q.push_back('{out_byte:   line[k],
                                     run_last:   (k == n - 1),
                                     frame_last: item.final_byte && (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        t_sfe_out exp_byte;
        if (!i_rst_n) begin
            line_bytes_q.delete();
            frame_crc = '0;
            in_frame  = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_line_bytes(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (line_bytes_q.size() == 0) begin
                    $error("out_byte: expected none, actual %02h", i_out_data.out_byte);
                    mismatches++;
                end else begin
                    exp_byte = line_bytes_q.pop_front();
                    if (i_out_data.out_byte !== exp_byte.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               exp_byte.out_byte, i_out_data.out_byte);
                        mismatches++;
                    end
                    if (i_out_data.run_last !== exp_byte.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               exp_byte.run_last, i_out_data.run_last);
                        mismatches++;
                    end
                    if (i_out_data.frame_last !== exp_byte.frame_last) begin
                        $error("frame_last: expected %0b, actual %0b",
                               exp_byte.frame_last, i_out_data.frame_last);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= line_bytes_q.size();
    end

endmodule

// ===== tb/sv/stuffed_frame_encoder_crc16_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame encoder testbench
// Drives directed and random frames into the encoder with random gaps and
// output backpressure, including one long receiver hold-off, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module stuffed_frame_encoder_crc16_tb;
    import sfe_pkg::*;

    localparam int unsigned TargetItems = 420;
    localparam int unsigned IdleLimit   = 3000;
    localparam int unsigned HoldOffLen  = 400;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_sfe_in  i_data  = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_sfe_out o_data;

    int mismatch_count;
    int bytes_outstanding;
    int items_sent    = 0;
    int idle_cycles   = 0;
    bit sender_no_gap = 1'b0;

    always #6 i_clk = ~i_clk;

    stuffed_frame_encoder_crc16 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    stuffed_frame_encoder_crc16_chk i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_data    (o_data),
        .o_mismatches  (mismatch_count),
        .o_outstanding (bytes_outstanding)
    );

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, final_byte: fin};
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Control codes and the all-zero and all-one bytes turn up far more often
    // than a flat draw would give them.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = START_BYTE;
            1:       b = ESC_BYTE;
            2:       b = END_BYTE;
            3:       b = 8'h00;
            4:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    initial begin
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Command-only frames, including every control code as the command.
        send_byte(START_BYTE, 1'b1);
        send_byte(ESC_BYTE, 1'b1);
        send_byte(END_BYTE, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // A frame whose payload holds both extremes and every control code.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(START_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        send_byte(8'h7E, 1'b1);
        sender_no_gap = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        sender_no_gap = 1'b0;

        while (items_sent < TargetItems) begin
            sender_no_gap = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 15) == 0) begin
                len = $urandom_range(30, 64);
            end else if ($urandom_range(0, 3) == 0) begin
                len = 1;
            end else begin
                len = $urandom_range(2, 10);
            end
            for (int k = 0; k < len; k++) begin
                send_byte(pick_byte(), (k == len - 1));
            end
        end
        i_valid <= 1'b0;

        // Let the last prediction show in the outstanding count first.
        @(posedge i_clk);
        while (bytes_outstanding != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stall before every output transaction, runs with no
    // stalling at all, and one long hold-off that backs the block up.
    initial begin
        int hold;
        int taken;
        bit free_run;
        taken    = 0;
        free_run = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ((taken % 50) == 0) begin
                free_run = ($urandom_range(0, 2) == 0);
            end
            if (taken == 40) begin
                hold = HoldOffLen;
            end else begin
                hold = free_run ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IdleLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
hdl/sfe_pkg.sv
hdl/sfe_front.sv
hdl/sfe_queue.sv
hdl/sfe_back.sv
hdl/stuffed_frame_encoder_crc16.sv
tb/sv/stuffed_frame_encoder_crc16_chk.sv
tb/sv/stuffed_frame_encoder_crc16_tb.sv
